// ===== src/bpt_pkg.sv =====
package bpt_pkg;

	// Field widths of the channels.
	localparam int RAW_W     = 24;
	localparam int COEF_W    = 16;
	localparam int TEMP_W    = 16;
	localparam int PRESS_W   = 17;
	localparam int CFG_IDX_W = 3;

	// Calibration register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_SENS       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TC    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TC  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE = 3'd5;

	// Compensation constants.
	localparam int TEMP_BASE       = 2000;
	localparam int TEMP_SHIFT      = 23;
	localparam int OFF_BASE_SHIFT  = 17;
	localparam int OFF_TC_SHIFT    = 6;
	localparam int SENS_BASE_SHIFT = 16;
	localparam int SENS_TC_SHIFT   = 7;
	localparam int PRESS_MUL_SHIFT = 21;
	localparam int PRESS_OUT_SHIFT = 15;
	localparam int REF_SHIFT       = 8;

	// Saturation bounds of the results.
	localparam logic signed [TEMP_W-1:0] TEMP_HI = 16'sh7FFF;
	localparam logic signed [TEMP_W-1:0] TEMP_LO = 16'sh8000;
	localparam logic [PRESS_W-1:0]       P_MAX   = 17'h1FFFF;

	// Factory calibration coefficients C1 to C6.
	typedef struct packed {
		logic [COEF_W-1:0] sens;
		logic [COEF_W-1:0] offset;
		logic [COEF_W-1:0] sens_tc;
		logic [COEF_W-1:0] offset_tc;
		logic [COEF_W-1:0] ref_temp;
		logic [COEF_W-1:0] temp_slope;
	} bpt_coef_t;

endpackage

// ===== src/bpt_sample_if.sv =====
interface bpt_sample_if import bpt_pkg::*;;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] pressure_raw;
	logic [RAW_W-1:0] temp_raw;

	modport source (output valid, output pressure_raw, output temp_raw, input ready);
	modport sink (input valid, input pressure_raw, input temp_raw, output ready);
endinterface

// ===== src/bpt_result_if.sv =====
interface bpt_result_if import bpt_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic [PRESS_W-1:0]       pressure_pa;
	logic                     out_of_range;

	modport source (output valid, output temperature_centi, output pressure_pa,
		output out_of_range, input ready);
	modport sink (input valid, input temperature_centi, input pressure_pa,
		input out_of_range, output ready);
endinterface

// ===== src/bpt_cfg_if.sv =====
interface bpt_cfg_if import bpt_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/bpt_pipe.sv =====
module bpt_pipe import bpt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  bpt_coef_t     coef,
	bpt_sample_if.sink    samples,
	bpt_result_if.source  results
);

	// Derived widths of the intermediate values.
	localparam int DT_W       = RAW_W + 1;
	localparam int PROD_W     = RAW_W + COEF_W + 1;
	localparam int TSH_W      = PROD_W - TEMP_SHIFT;
	localparam int TFULL_W    = TSH_W + 1;
	localparam int OFF_W      = OFF_BASE_SHIFT + COEF_W + 3;
	localparam int SENS_W     = SENS_BASE_SHIFT + COEF_W + 3;
	localparam int SENS_SPLIT = 18;
	localparam int PP_LO_W    = RAW_W + SENS_SPLIT;
	localparam int PP_HI_W    = RAW_W + SENS_W - SENS_SPLIT;
	localparam int MUL_W      = PP_HI_W + SENS_SPLIT;
	localparam int Q_W        = MUL_W - PRESS_MUL_SHIFT;
	localparam int DIFF_W     = Q_W + 1;
	localparam int PSH_W      = DIFF_W - PRESS_OUT_SHIFT;

	localparam logic signed [TFULL_W-1:0] TFULL_HI = TFULL_W'(TEMP_HI);
	localparam logic signed [TFULL_W-1:0] TFULL_LO = TFULL_W'(TEMP_LO);
	localparam logic signed [PSH_W-1:0]   PSH_MAX  = PSH_W'(P_MAX);

	// Stage valid bits and advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	// Stage payload registers.
	logic signed [DT_W-1:0]    dt_s1;
	logic [RAW_W-1:0]          d1_s1, d1_s2, d1_s3;
	logic signed [PROD_W-1:0]  m6_s2, m4_s2, m3_s2;
	logic signed [TEMP_W-1:0]  temp_s3, temp_s4, temp_s5, temp_s6;
	logic                      tflag_s3, tflag_s4, tflag_s5, flag_s6;
	logic signed [OFF_W-1:0]   off_s3, off_s4, off_s5;
	logic signed [SENS_W-1:0]  sens_s3;
	logic [PP_LO_W-1:0]        pp_lo_s4;
	logic signed [PP_HI_W-1:0] pp_hi_s4;
	logic signed [Q_W-1:0]     q_s5;
	logic [PRESS_W-1:0]        p_s6;

	// Combinational values between the stages.
	logic signed [DT_W-1:0]     dt_c;
	logic signed [PROD_W:0]     m6_c, m4_c, m3_c;
	logic signed [TFULL_W-1:0]  temp_full_c;
	logic signed [TEMP_W-1:0]   temp_c;
	logic                       tflag_c;
	logic signed [OFF_W-1:0]    off_c;
	logic signed [SENS_W-1:0]   sens_c;
	logic [PP_LO_W-1:0]         pp_lo_c;
	logic signed [PP_HI_W:0]    pp_hi_c;
	logic signed [MUL_W-1:0]    mul_c;
	logic signed [DIFF_W-1:0]   diff_c;
	logic signed [PSH_W-1:0]    psh_c;
	logic [PRESS_W-1:0]         p_c;
	logic                       pflag_c;

	// A stage moves on when it is empty or when the stage after it moves.
	assign en_s6 = !v_s6 || results.ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign samples.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= samples.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: temperature difference from the reference.
	assign dt_c = $signed({1'b0, samples.temp_raw})
		- $signed({1'b0, coef.ref_temp, {REF_SHIFT{1'b0}}});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dt_s1 <= dt_c;
			d1_s1 <= samples.pressure_raw;
		end
	end

	// Stage 2: the three temperature products.
	assign m6_c = dt_s1 * $signed({1'b0, coef.temp_slope});
	assign m4_c = dt_s1 * $signed({1'b0, coef.offset_tc});
	assign m3_c = dt_s1 * $signed({1'b0, coef.sens_tc});

	always_ff @(posedge clk) begin
		if (en_s2) begin
			m6_s2 <= m6_c[PROD_W-1:0];
			m4_s2 <= m4_c[PROD_W-1:0];
			m3_s2 <= m3_c[PROD_W-1:0];
			d1_s2 <= d1_s1;
		end
	end

	// Stage 3: temperature with saturation, offset and sensitivity.
	assign temp_full_c = $signed({m6_s2[PROD_W-1], m6_s2[PROD_W-1:TEMP_SHIFT]})
		+ $signed(TFULL_W'(TEMP_BASE));

	always_comb begin
		priority if (temp_full_c > TFULL_HI) begin
			temp_c  = TEMP_HI;
			tflag_c = 1'b1;
		end else if (temp_full_c < TFULL_LO) begin
			temp_c  = TEMP_LO;
			tflag_c = 1'b1;
		end else begin
			temp_c  = temp_full_c[TEMP_W-1:0];
			tflag_c = 1'b0;
		end
	end

	assign off_c = $signed({{(OFF_W-COEF_W-OFF_BASE_SHIFT){1'b0}}, coef.offset,
		{OFF_BASE_SHIFT{1'b0}}})
		+ $signed({{(OFF_W-PROD_W+OFF_TC_SHIFT){m4_s2[PROD_W-1]}},
		m4_s2[PROD_W-1:OFF_TC_SHIFT]});

	assign sens_c = $signed({{(SENS_W-COEF_W-SENS_BASE_SHIFT){1'b0}}, coef.sens,
		{SENS_BASE_SHIFT{1'b0}}})
		+ $signed({{(SENS_W-PROD_W+SENS_TC_SHIFT){m3_s2[PROD_W-1]}},
		m3_s2[PROD_W-1:SENS_TC_SHIFT]});

	always_ff @(posedge clk) begin
		if (en_s3) begin
			temp_s3  <= temp_c;
			tflag_s3 <= tflag_c;
			off_s3   <= off_c;
			sens_s3  <= sens_c;
			d1_s3    <= d1_s2;
		end
	end

	// Stage 4: pressure times sensitivity as two partial products.
	assign pp_lo_c = d1_s3 * sens_s3[SENS_SPLIT-1:0];
	assign pp_hi_c = $signed({1'b0, d1_s3}) * $signed(sens_s3[SENS_W-1:SENS_SPLIT]);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			pp_lo_s4 <= pp_lo_c;
			pp_hi_s4 <= pp_hi_c[PP_HI_W-1:0];
			temp_s4  <= temp_s3;
			tflag_s4 <= tflag_s3;
			off_s4   <= off_s3;
		end
	end

	// Stage 5: join the partial products and scale down.
	assign mul_c = $signed({pp_hi_s4, {SENS_SPLIT{1'b0}}})
		+ $signed({{(MUL_W-PP_LO_W){1'b0}}, pp_lo_s4});

	always_ff @(posedge clk) begin
		if (en_s5) begin
			q_s5     <= mul_c[MUL_W-1:PRESS_MUL_SHIFT];
			temp_s5  <= temp_s4;
			tflag_s5 <= tflag_s4;
			off_s5   <= off_s4;
		end
	end

	// Stage 6: remove the offset, scale and saturate the pressure.
	assign diff_c = $signed({q_s5[Q_W-1], q_s5})
		- $signed({{(DIFF_W-OFF_W){off_s5[OFF_W-1]}}, off_s5});
	assign psh_c = diff_c[DIFF_W-1:PRESS_OUT_SHIFT];

	always_comb begin
		priority if (psh_c < 0) begin
			p_c     = '0;
			pflag_c = 1'b1;
		end else if (psh_c > PSH_MAX) begin
			p_c     = P_MAX;
			pflag_c = 1'b1;
		end else begin
			p_c     = psh_c[PRESS_W-1:0];
			pflag_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			temp_s6 <= temp_s5;
			p_s6    <= p_c;
			flag_s6 <= tflag_s5 | pflag_c;
		end
	end

	assign results.valid             = v_s6;
	assign results.temperature_centi = temp_s6;
	assign results.pressure_pa       = p_s6;
	assign results.out_of_range      = flag_s6;

	// An accepted sample always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> v_s1)
		else $error("accepted sample did not enter stage 1");

	// The input side only stalls while stage 1 holds an item.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> v_s1)
		else $error("input stalled with stage 1 empty");

	// A held stage keeps its item.
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !en_s5 |=> v_s5 && $stable(q_s5) && $stable(off_s5))
		else $error("stage 5 lost or changed a held item");

	// A saturated temperature sits on one of its bounds.
	a_temp_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && tflag_s4 |-> temp_s4 == TEMP_HI || temp_s4 == TEMP_LO)
		else $error("temperature flagged but not at a bound");

	// A result that waits at the output stays unchanged until its transfer.
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid && $stable(temp_s6)
		&& $stable(p_s6) && $stable(flag_s6))
		else $error("waiting result lost or changed");

endmodule

// ===== src/baro_pressure_temp_compensation_top.sv =====
// First-order barometric compensation, six register stages.
// An accepted sample passes through stages 1 to 6 in order.
// Throughput: one sample per cycle while results.ready is high; the rate is set
// by the stage chain, each stage holding multipliers or wide adds.
// Reset clears all stage valid bits and the calibration registers to zero.
module baro_pressure_temp_compensation_top import bpt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bpt_cfg_if.sink       cfg,
	bpt_sample_if.sink    samples,
	bpt_result_if.source  results
);

	bpt_coef_t coef_q;

	// Calibration writes are always accepted; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SENS:       coef_q.sens       <= cfg.data;
				REG_OFFSET:     coef_q.offset     <= cfg.data;
				REG_SENS_TC:    coef_q.sens_tc    <= cfg.data;
				REG_OFFSET_TC:  coef_q.offset_tc  <= cfg.data;
				REG_REF_TEMP:   coef_q.ref_temp   <= cfg.data;
				REG_TEMP_SLOPE: coef_q.temp_slope <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Compensation pipeline.
	bpt_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef_q),
		.samples (samples),
		.results (results)
	);

endmodule
